// ----- rtl/gbpi_pkg.sv -----
package gbpi_pkg;

    // Command codes carried by the input transaction.
    localparam logic [2:0] CMD_WRITE_CELL  = 3'd0;
    localparam logic [2:0] CMD_WRITE_LABEL = 3'd1;
    localparam logic [2:0] CMD_CLEAR       = 3'd2;
    localparam logic [2:0] CMD_READY       = 3'd3;
    localparam logic [2:0] CMD_START       = 3'd4;
    localparam logic [2:0] CMD_STOP        = 3'd5;
    localparam logic [2:0] CMD_HIT         = 3'd6;
    localparam logic [2:0] CMD_STEP        = 3'd7;

    // Block types held in bits 7..6 of a cell.
    localparam logic [1:0] BLK_BASIC  = 2'd0;
    localparam logic [1:0] BLK_LABEL  = 2'd1;
    localparam logic [1:0] BLK_JUMP   = 2'd2;
    localparam logic [1:0] BLK_BRANCH = 2'd3;

    // Branch conditions selected by the serial of a branch cell.
    localparam logic [4:0] COND_HIT   = 5'd1;
    localparam logic [4:0] COND_TDOWN = 5'd2;

    // Halt codes.
    localparam logic [1:0] HALT_NONE   = 2'd0;
    localparam logic [1:0] HALT_NORMAL = 2'd1;
    localparam logic [1:0] HALT_ERROR  = 2'd2;

    // Grid geometry: positions are packed as {row, col} of three bits each.
    localparam int unsigned ROWS     = 8;
    localparam int unsigned COLS     = 8;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned GRID_AW  = 2 * POS_W;
    localparam int unsigned GRID_N   = ROWS * COLS;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned SERIAL_W = 5;
    localparam logic [POS_W-1:0] SKIP = 3'd2;

    typedef struct packed {
        logic accept_simple;  // a non-step item, or a step while stopped
        logic accept_step;    // a step while running: begin the fetch
        logic fetch;          // current cell is on the read port
        logic exec;           // neighbours are on the read ports
        logic load_out;       // capture a result into the output register
    } t_ctrl_cmd;

    typedef struct packed {
        logic step_go;        // the offered item is a step and the program runs
    } t_dp_status;

endpackage

// ----- rtl/gbpi_grid.sv -----
module gbpi_grid (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [gbpi_pkg::GRID_AW-1:0]        i_waddr,
    input  logic [gbpi_pkg::CODE_W-1:0]         i_wdata,
    input  logic [gbpi_pkg::GRID_AW-1:0]        i_raddr_a,
    input  logic [gbpi_pkg::GRID_AW-1:0]        i_raddr_b,
    output logic [gbpi_pkg::CODE_W-1:0]         o_rdata_a,
    output logic [gbpi_pkg::CODE_W-1:0]         o_rdata_b
);

    logic [gbpi_pkg::CODE_W-1:0]  r_mem [gbpi_pkg::GRID_N];
    logic [gbpi_pkg::GRID_N-1:0]  r_written;
    logic [gbpi_pkg::CODE_W-1:0]  r_rd_a;
    logic [gbpi_pkg::CODE_W-1:0]  r_rd_b;
    logic                         r_rv_a;
    logic                         r_rv_b;

    // Cells never written read as zero, so reset only clears the written bits.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rv_a    <= 1'b0;
            r_rv_b    <= 1'b0;
        end else begin
            if (i_we) begin
                r_written[i_waddr] <= 1'b1;
            end
            r_rv_a <= r_written[i_raddr_a];
            r_rv_b <= r_written[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rv_a ? r_rd_a : '0;
    assign o_rdata_b = r_rv_b ? r_rd_b : '0;

endmodule

// ----- rtl/gbpi_ctrl.sv -----
module gbpi_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    output logic                    o_valid,
    input  logic                    i_ready,
    input  gbpi_pkg::t_dp_status    i_sts,
    output gbpi_pkg::t_ctrl_cmd     o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_fire;

    assign o_ready = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign in_fire = i_valid && o_ready;
    assign o_valid = r_out_valid;

    always_comb begin
        o_cmd.accept_simple = in_fire && !i_sts.step_go;
        o_cmd.accept_step   = in_fire && i_sts.step_go;
        o_cmd.fetch         = (r_state == ST_FETCH);
        o_cmd.exec          = (r_state == ST_EXEC);
        o_cmd.load_out      = o_cmd.accept_simple || o_cmd.exec;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_sts.step_go) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/gbpi_dp.sv -----
module gbpi_dp #(
    parameter int LABELS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gbpi_pkg::t_ctrl_cmd                 i_cmd_ctl,
    output gbpi_pkg::t_dp_status                o_sts,
    input  logic [2:0]                          i_cmd,
    input  logic [gbpi_pkg::POS_W-1:0]          i_row,
    input  logic [gbpi_pkg::POS_W-1:0]          i_col,
    input  logic [gbpi_pkg::CODE_W-1:0]         i_code,
    input  logic [3:0]                          i_label_index,
    input  logic                                i_targets_down,
    output logic [gbpi_pkg::SERIAL_W-1:0]       o_action,
    output logic                                o_is_running,
    output logic                                o_is_ready,
    output logic [1:0]                          o_halt,
    output logic [gbpi_pkg::POS_W-1:0]          o_cur_row,
    output logic [gbpi_pkg::POS_W-1:0]          o_cur_col
);

    localparam int NSLOT = LABELS + 1;
    localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    // Architectural state.
    logic [gbpi_pkg::GRID_AW-1:0]   r_label_pos [NSLOT];
    logic [NSLOT-1:0]               r_label_valid;
    logic [NSLOT-1:0]               n_label_valid;
    logic [gbpi_pkg::POS_W-1:0]     r_pos_row, n_pos_row;
    logic [gbpi_pkg::POS_W-1:0]     r_pos_col, n_pos_col;
    logic                           r_run, n_run;
    logic                           r_rdy, n_rdy;
    logic                           r_error, n_error;
    logic                           r_hit, n_hit;

    // Step working registers.
    logic                           r_tdown;
    logic [gbpi_pkg::CODE_W-1:0]    r_cell;
    logic                           r_right_in;
    logic                           r_down_in;

    // Result register.
    logic [gbpi_pkg::SERIAL_W-1:0]  r_out_action;
    logic                           r_out_run;
    logic                           r_out_rdy;
    logic [1:0]                     r_out_halt;
    logic [gbpi_pkg::POS_W-1:0]     r_out_row;
    logic [gbpi_pkg::POS_W-1:0]     r_out_col;
    logic [gbpi_pkg::SERIAL_W-1:0]  n_action;
    logic [1:0]                     n_halt;

    // Grid port signals.
    logic                           grid_we;
    logic [gbpi_pkg::GRID_AW-1:0]   raddr_a, raddr_b;
    logic [gbpi_pkg::CODE_W-1:0]    rd_a, rd_b;
    logic [3:0]                     nb_step;
    logic [3:0]                     nb_col_sum, nb_row_sum;

    // Write decode.
    logic                           wr_in_grid;
    logic [5:0]                     li_ext;
    logic                           li_in;
    logic [SW-1:0]                  wslot;

    // Step decode.
    logic [1:0]                     typ;
    logic [gbpi_pkg::SERIAL_W-1:0]  ser;
    logic                           basic_ok;
    logic                           right_nz, down_nz;
    logic                           ser_in;
    logic [SW-1:0]                  jslot;
    logic                           jmp_ok;
    logic                           cond;
    logic [gbpi_pkg::POS_W-1:0]     mv_n;
    logic [gbpi_pkg::POS_W-1:0]     col_mv, row_mv;
    logic                           st_err, st_ok, st_hitclr;
    logic [gbpi_pkg::SERIAL_W-1:0]  st_act;
    logic [gbpi_pkg::POS_W-1:0]     st_row, st_col;

    assign o_sts.step_go = (i_cmd == gbpi_pkg::CMD_STEP) && r_run;

    // ---------------------------------------------------------------
    // Grid access: the current cell is read while idle, the neighbours
    // one or two cells away while the current cell is decoded.
    // ---------------------------------------------------------------
    assign wr_in_grid = ({1'b0, i_row} < 4'(gbpi_pkg::ROWS)) &&
                        ({1'b0, i_col} < 4'(gbpi_pkg::COLS));
    assign grid_we    = i_cmd_ctl.accept_simple && (i_cmd == gbpi_pkg::CMD_WRITE_CELL) &&
                        wr_in_grid;

    assign nb_step    = (rd_a[7:6] == gbpi_pkg::BLK_BRANCH) ? 4'({1'b0, gbpi_pkg::SKIP})
                                                            : 4'd1;
    assign nb_col_sum = {1'b0, r_pos_col} + nb_step;
    assign nb_row_sum = {1'b0, r_pos_row} + nb_step;
    assign raddr_a    = i_cmd_ctl.fetch ? {r_pos_row, nb_col_sum[2:0]} : {r_pos_row, r_pos_col};
    assign raddr_b    = {nb_row_sum[2:0], r_pos_col};

    gbpi_grid u_grid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (grid_we),
        .i_waddr   ({i_row, i_col}),
        .i_wdata   (i_code),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept_step) begin
            r_tdown <= i_targets_down;
        end
        if (i_cmd_ctl.fetch) begin
            r_cell     <= rd_a;
            r_right_in <= nb_col_sum < 4'(gbpi_pkg::COLS);
            r_down_in  <= nb_row_sum < 4'(gbpi_pkg::ROWS);
        end
    end

    // ---------------------------------------------------------------
    // Label writes.
    // ---------------------------------------------------------------
    assign li_ext = {2'b00, i_label_index};
    assign li_in  = (li_ext <= 6'(LABELS)) && wr_in_grid;
    assign wslot  = li_ext[SW-1:0];

    // Slot 0 is read by a start even when it was never written, so every
    // stored position starts from zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                r_label_pos[i] <= '0;
            end
        end else if (i_cmd_ctl.accept_simple && (i_cmd == gbpi_pkg::CMD_WRITE_LABEL) &&
                     li_in) begin
            r_label_pos[wslot] <= {i_row, i_col};
        end
    end

    // ---------------------------------------------------------------
    // Step decode.
    // ---------------------------------------------------------------
    assign typ      = r_cell[7:6];
    assign ser      = r_cell[4:0];
    assign basic_ok = (ser == 5'd1) || (ser == 5'd2) || (ser == 5'd3) ||
                      (ser == 5'd4) || (ser == 5'd7) || (ser == 5'd8);
    assign right_nz = r_right_in && (rd_a != '0);
    assign down_nz  = r_down_in && (rd_b != '0);
    assign ser_in   = (ser != '0) && ({1'b0, ser} <= 6'(LABELS));
    assign jslot    = ser[SW-1:0];
    assign jmp_ok   = ser_in && r_label_valid[jslot];
    assign cond     = (ser == gbpi_pkg::COND_HIT) ? r_hit : r_tdown;
    assign mv_n     = (typ == gbpi_pkg::BLK_BRANCH) ? gbpi_pkg::SKIP : 3'd1;
    assign col_mv   = r_pos_col + mv_n;
    assign row_mv   = r_pos_row + mv_n;

    always_comb begin
        st_err    = r_error;
        st_ok     = 1'b0;
        st_hitclr = 1'b0;
        st_act    = '0;
        st_row    = r_pos_row;
        st_col    = r_pos_col;
        unique case (typ) inside
            gbpi_pkg::BLK_BASIC, gbpi_pkg::BLK_LABEL: begin
                if (typ == gbpi_pkg::BLK_BASIC) begin
                    if (basic_ok) begin
                        st_act = ser;
                    end else begin
                        st_err = 1'b1;
                    end
                end
                st_ok = !st_err && (right_nz ^ down_nz);
                if (right_nz) begin
                    st_col = col_mv;
                end else begin
                    st_row = row_mv;
                end
            end
            gbpi_pkg::BLK_JUMP: begin
                if (!jmp_ok) begin
                    st_err = 1'b1;
                end
                st_ok  = jmp_ok;
                st_row = r_label_pos[jslot][5:3];
                st_col = r_label_pos[jslot][2:0];
            end
            default: begin
                if ((ser != gbpi_pkg::COND_HIT) && (ser != gbpi_pkg::COND_TDOWN)) begin
                    st_err = 1'b1;
                end
                if (cond) begin
                    st_ok  = !st_err && right_nz;
                    st_col = col_mv;
                end else begin
                    st_ok  = !st_err && down_nz;
                    st_row = row_mv;
                end
                st_hitclr = st_ok;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Next state for both directly accepted items and the end of a step.
    // ---------------------------------------------------------------
    always_comb begin
        n_label_valid = r_label_valid;
        n_pos_row     = r_pos_row;
        n_pos_col     = r_pos_col;
        n_run         = r_run;
        n_rdy         = r_rdy;
        n_error       = r_error;
        n_hit         = r_hit;
        n_action      = '0;
        n_halt        = gbpi_pkg::HALT_NONE;

        if (i_cmd_ctl.accept_simple) begin
            unique case (i_cmd)
                gbpi_pkg::CMD_WRITE_LABEL: begin
                    if (li_in) begin
                        n_label_valid[wslot] = 1'b1;
                    end
                end
                gbpi_pkg::CMD_CLEAR: begin
                    n_rdy         = 1'b0;
                    n_run         = 1'b0;
                    n_label_valid = '0;
                end
                gbpi_pkg::CMD_READY: begin
                    n_error = 1'b0;
                    n_rdy   = 1'b1;
                end
                gbpi_pkg::CMD_START: begin
                    if (r_rdy && !r_run) begin
                        n_pos_row = r_label_pos[0][5:3];
                        n_pos_col = r_label_pos[0][2:0];
                        n_hit     = 1'b0;
                        n_run     = 1'b1;
                    end
                end
                gbpi_pkg::CMD_STOP: begin
                    if (r_rdy) begin
                        n_run = 1'b0;
                    end
                end
                gbpi_pkg::CMD_HIT: begin
                    if (r_rdy) begin
                        n_hit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd_ctl.exec) begin
            n_error  = st_err;
            n_action = st_act;
            if (st_ok) begin
                n_pos_row = st_row;
                n_pos_col = st_col;
                if (st_hitclr) begin
                    n_hit = 1'b0;
                end
            end else if (st_err) begin
                n_rdy         = 1'b0;
                n_run         = 1'b0;
                n_label_valid = '0;
                n_action      = '0;
                n_halt        = gbpi_pkg::HALT_ERROR;
            end else begin
                n_run  = 1'b0;
                n_halt = gbpi_pkg::HALT_NORMAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_valid <= '0;
            r_pos_row     <= '0;
            r_pos_col     <= '0;
            r_run         <= 1'b0;
            r_rdy         <= 1'b0;
            r_error       <= 1'b0;
            r_hit         <= 1'b0;
        end else begin
            r_label_valid <= n_label_valid;
            r_pos_row     <= n_pos_row;
            r_pos_col     <= n_pos_col;
            r_run         <= n_run;
            r_rdy         <= n_rdy;
            r_error       <= n_error;
            r_hit         <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load_out) begin
            r_out_action <= n_action;
            r_out_run    <= n_run;
            r_out_rdy    <= n_rdy;
            r_out_halt   <= n_halt;
            r_out_row    <= n_pos_row;
            r_out_col    <= n_pos_col;
        end
    end

    assign o_action     = r_out_action;
    assign o_is_running = r_out_run;
    assign o_is_ready   = r_out_rdy;
    assign o_halt       = r_out_halt;
    assign o_cur_row    = r_out_row;
    assign o_cur_col    = r_out_col;

endmodule

// ----- rtl/grid_block_program_interpreter_core.sv -----
// Grid block program interpreter.
// One input channel (i_valid / o_ready) carries a command transaction: cell and
// label writes, clear, ready, start, stop, hit and step. Each input transaction
// gives exactly one result transaction on the output channel (o_valid / i_ready)
// with the emitted action, the running and ready flags, the halt code and the
// cursor position after the command.
// Every command other than a step of a running program finishes in the cycle it
// is accepted, so its registered result is valid in the next cycle, and a new
// transaction may follow in the very next cycle if that result is taken. A step
// of a running program first reads the current cell from the grid memory, then
// reads its right and down neighbours (one or two cells away) on the memory's two
// read ports, then resolves the step; no new transaction is taken before that.
// The registered reads of the 64-entry grid memory call for these phases.
// The output register parts the two channels: an input transaction is taken while
// a result still waits, provided that result is being taken in the same cycle.
// When the receiver stalls, the result holds and o_ready falls until it is taken.
// Reset (i_rst_n low, synchronous) clears the flags, cursor, label valid bits and
// the written bits of the grid, so every cell and label position reads as zero.
module grid_block_program_interpreter_core #(
    parameter int LABELS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_row,
    input  logic [2:0]  i_col,
    input  logic [7:0]  i_code,
    input  logic [3:0]  i_label_index,
    input  logic        i_targets_down,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_action,
    output logic        o_is_running,
    output logic        o_is_ready,
    output logic [1:0]  o_halt,
    output logic [2:0]  o_cur_row,
    output logic [2:0]  o_cur_col
);

    // Command and status between the sequencer and the datapath.
    gbpi_pkg::t_ctrl_cmd  ctl_cmd;
    gbpi_pkg::t_dp_status dp_sts;

    // The controller owns both handshakes and walks a step through its
    // fetch and execute cycles.
    gbpi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (dp_sts),
        .o_cmd   (ctl_cmd)
    );

    // The datapath holds the grid, the labels, the cursor, the flags and the
    // result register.
    gbpi_dp #(
        .LABELS (LABELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_ctl      (ctl_cmd),
        .o_sts          (dp_sts),
        .i_cmd          (i_cmd),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_code         (i_code),
        .i_label_index  (i_label_index),
        .i_targets_down (i_targets_down),
        .o_action       (o_action),
        .o_is_running   (o_is_running),
        .o_is_ready     (o_is_ready),
        .o_halt         (o_halt),
        .o_cur_row      (o_cur_row),
        .o_cur_col      (o_cur_col)
    );

endmodule
